@@ src/assert_macros.svh @@
// assertion macros used by the zscore peak detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ZPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression must never be true outside reset
`define ZPD_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ZPD_ASSERT(lbl, clk, rstn, prop, msg)
`define ZPD_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

@@ src/zpd_pkg.sv @@
// shared types and constants of the zscore peak detector
package zpd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 24;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 48;
    localparam int DIV_W    = 64;
    localparam int CFG_W    = 17;
    localparam int SIG_W    = 2;

    localparam logic [1:0] REG_WINDOW    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_SMOOTHING = 2'd2;
    localparam logic [1:0] REG_PERIOD    = 2'd3;

    localparam logic [8:0]  WINDOW_RST    = 9'd32;
    localparam logic [11:0] THRESHOLD_RST = 12'd768;
    localparam logic [16:0] SMOOTHING_RST = 17'd32768;
    localparam logic [15:0] PERIOD_RST    = 16'd100;

    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [41:0] PEAK_ROUND = 42'd32768;

    localparam logic [SIG_W-1:0] SIG_NONE = 2'b00;
    localparam logic [SIG_W-1:0] SIG_POS  = 2'b01;
    localparam logic [SIG_W-1:0] SIG_NEG  = 2'b11;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_RD_OLD, S_TH2, S_TH2_CAP, S_VHI, S_VLO, S_CMP,
        S_PK1, S_PK2, S_WR, S_SUM_RD, S_SUM_ACC, S_MDIV, S_DIV_WAIT, S_MSET,
        S_VAR_RD, S_VAR_MUL, S_VAR_ACC, S_VDIV, S_VSET, S_DM, S_DMSET, S_MNEW,
        S_ADIV, S_AACC, S_BDIV, S_BACC, S_TDIV, S_TACC, S_DX, S_DHI, S_DLO,
        S_DDIV, S_DACC, S_ISET, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_START, OP_RD_OLD, OP_TH2, OP_TH2_CAP, OP_VHI,
        OP_VLO, OP_CMP, OP_PK1, OP_PK2, OP_WR, OP_SUM_RD, OP_SUM_ACC, OP_MSET,
        OP_VAR_MUL, OP_VAR_ACC, OP_VSET, OP_DMSET, OP_MNEW, OP_AACC, OP_BACC,
        OP_TACC, OP_DX, OP_DHI, OP_DLO, OP_DACC, OP_ISET, OP_FINISH
    } dp_op_t;

    typedef enum logic [2:0] {
        DIV_MEAN, DIV_VAR, DIV_DM, DIV_A, DIV_B, DIV_T, DIV_D
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic period_zero;
        logic idx_last;
        logic clr_last;
    } dp_status_t;

endpackage

@@ src/zpd_div.sv @@
// restoring divider with round to nearest, one quotient bit per cycle
module zpd_div #(
    parameter int NW = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [zpd_pkg::DIV_W-1:0] dividend,
    input  logic [NW-1:0]             divisor,
    output logic                      busy,
    output logic                      done,
    output logic [zpd_pkg::DIV_W-1:0] quotient
);
    import zpd_pkg::*;

    localparam int CW = $clog2(DIV_W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [NW:0]     rem_sh;
    logic            fits;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // bias by half the divisor so truncation rounds to nearest
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend + DIV_W'(divisor >> 1);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? NW'(rem_sh - {1'b0, divisor}) : rem_sh[NW-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/zpd_datapath.sv @@
// datapath: config registers, value ring, shared multiplier, divider and statistics
module zpd_datapath #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  zpd_pkg::dp_cmd_t             cmd,
    output zpd_pkg::dp_status_t          st,
    input  logic [zpd_pkg::SAMPLE_W-1:0] sample,
    output logic [zpd_pkg::SIG_W-1:0]    peak_signal,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [zpd_pkg::CFG_W-1:0]    cfg_data
);
    import zpd_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int NW = $clog2(MAX_WINDOW + 1);
    localparam int FW = $clog2(MAX_WINDOW + 2);
    localparam logic [NW-1:0] MAX_N    = NW'(MAX_WINDOW);
    localparam logic [FW-1:0] FILL_TOP = FW'(MAX_WINDOW + 1);
    localparam logic [AW-1:0] LAST_A   = AW'(MAX_WINDOW - 1);
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
    localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

    logic [8:0]  cfg_window_reg;
    logic [11:0] cfg_thresh_reg;
    logic [16:0] cfg_smooth_reg;
    logic [15:0] cfg_period_reg;

    logic [VAL_W-1:0] ring [MAX_WINDOW];
    logic [VAL_W-1:0] rdata_reg;
    logic [AW-1:0]    raddr;
    logic             ring_we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;

    logic [SAMPLE_W-1:0] y_reg;
    logic [NW-1:0]       n_reg;
    logic [AW-1:0]       p_reg, prev_reg, wp_reg, idx_reg;
    logic [FW-1:0]       fill_reg;
    logic [15:0]         pcnt_reg;
    logic [MEAN_W-1:0]   mean_reg, mnew_reg;
    logic [VAR_W-1:0]    var_reg;
    logic [VAL_W-1:0]    b_old_reg, b_new_reg, prev_val_reg;
    logic [63:0]         d2_reg, mul_reg, sum_reg;
    logic [23:0]         th2_reg;
    logic [47:0]         hi_reg, x_reg;
    logic [40:0]         acc_reg;
    logic                sig_reg, neg_reg, dm_neg_reg;
    logic [31:0]         dmm_reg;
    logic signed [63:0]  vacc_reg;
    logic [SIG_W-1:0]    out_sig_reg;

    logic [NW-1:0]     n_eff, nm1;
    logic [AW-1:0]     p_start, prev_start;
    logic [16:0]       alpha;
    logic [15:0]       period_eff;
    logic [31:0]       y_sh, bo_sh, bn_sh, e_sh;
    logic              dy_pos, eold_neg, diff_neg;
    logic [31:0]       d_mag, a_mag, b_mag, e_mag;
    logic [23:0]       diff_mag;
    logic              mul_en;
    logic [31:0]       mul_a, mul_b;
    logic [DIV_W-1:0]  div_dividend, q;
    logic [71:0]       th_prod;
    logic [41:0]       peak_acc;
    logic [32:0]       mean_up;
    logic [16:0]       pcnt_inc;

    // effective window and start position of this transaction
    always_comb
    begin
        if (cfg_window_reg == 9'd0)
            n_eff = NW'(1);
        else if (32'(cfg_window_reg) > 32'(MAX_WINDOW))
            n_eff = MAX_N;
        else
            n_eff = NW'(cfg_window_reg);
        p_start    = (NW'(wp_reg) >= n_eff) ? '0 : wp_reg;
        prev_start = (p_start == '0) ? AW'(n_eff - 1'b1) : p_start - 1'b1;
    end

    assign nm1        = n_reg - 1'b1;
    assign alpha      = (cfg_smooth_reg > ALPHA_ONE) ? ALPHA_ONE : cfg_smooth_reg;
    assign period_eff = (cfg_period_reg == 16'd0) ? 16'd1 : cfg_period_reg;

    assign y_sh     = {y_reg, 16'b0};
    assign dy_pos   = y_sh > mean_reg;
    assign d_mag    = dy_pos ? y_sh - mean_reg : mean_reg - y_sh;
    assign bo_sh    = {b_old_reg, 8'b0};
    assign eold_neg = bo_sh < mean_reg;
    assign a_mag    = eold_neg ? mean_reg - bo_sh : bo_sh - mean_reg;
    assign bn_sh    = {b_new_reg, 8'b0};
    assign b_mag    = (bn_sh < mnew_reg) ? mnew_reg - bn_sh : bn_sh - mnew_reg;
    assign e_sh     = {rdata_reg, 8'b0};
    assign e_mag    = (e_sh < mean_reg) ? mean_reg - e_sh : e_sh - mean_reg;
    assign diff_neg = b_new_reg < b_old_reg;
    assign diff_mag = diff_neg ? b_old_reg - b_new_reg : b_new_reg - b_old_reg;

    assign th_prod  = {hi_reg, 24'b0} + 72'(mul_reg[47:0]);
    assign peak_acc = 42'(acc_reg) + 42'(mul_reg[40:0]) + PEAK_ROUND;
    assign mean_up  = 33'(mean_reg) + 33'(dmm_reg);
    assign pcnt_inc = 17'(pcnt_reg) + 17'd1;

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_RD_OLD:
            begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            OP_TH2:
            begin
                mul_a = 32'(cfg_thresh_reg);
                mul_b = 32'(cfg_thresh_reg);
            end
            OP_VHI:
            begin
                mul_a = 32'(th2_reg);
                mul_b = 32'(var_reg[47:24]);
            end
            OP_VLO:
            begin
                mul_a = 32'(th2_reg);
                mul_b = 32'(var_reg[23:0]);
            end
            OP_CMP:
            begin
                mul_a = 32'(alpha);
                mul_b = 32'({y_reg, 8'b0});
            end
            OP_PK1:
            begin
                mul_a = 32'(ALPHA_ONE - alpha);
                mul_b = 32'(prev_val_reg);
            end
            OP_VAR_MUL:
            begin
                mul_a = e_mag;
                mul_b = e_mag;
            end
            OP_MNEW:
            begin
                mul_a = a_mag;
                mul_b = a_mag;
            end
            OP_AACC:
            begin
                mul_a = b_mag;
                mul_b = b_mag;
            end
            OP_BACC:
            begin
                mul_a = dmm_reg;
                mul_b = a_mag;
            end
            OP_TACC:
            begin
                mul_a = dmm_reg;
                mul_b = dmm_reg;
            end
            OP_DHI:
            begin
                mul_a = 32'(x_reg[47:24]);
                mul_b = 32'(nm1);
            end
            OP_DLO:
            begin
                mul_a = 32'(x_reg[23:0]);
                mul_b = 32'(nm1);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN: div_dividend = {sum_reg[55:0], 8'b0};
            DIV_VAR:  div_dividend = sum_reg;
            DIV_DM:   div_dividend = 64'({diff_mag, 8'b0});
            DIV_A:    div_dividend = 64'(mul_reg[63:16]);
            DIV_B:    div_dividend = 64'(mul_reg[63:16]);
            DIV_T:    div_dividend = 64'(mul_reg[63:15]);
            DIV_D:    div_dividend = 64'({hi_reg, 24'b0}) + 64'(mul_reg[47:0]);
            default:  div_dividend = '0;
        endcase
    end

    zpd_div #(
        .NW(NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .busy     (st.div_busy),
        .done     (st.div_done),
        .quotient (q)
    );

    // ring port select
    always_comb
    begin
        ring_we = 1'b0;
        waddr   = p_reg;
        wdata   = b_new_reg;
        case (cmd.op)
            OP_RD_OLD: raddr = p_reg;
            OP_VHI:    raddr = prev_reg;
            default:   raddr = idx_reg;
        endcase
        case (cmd.op)
            OP_CLR:
            begin
                ring_we = 1'b1;
                waddr   = idx_reg;
                wdata   = '0;
            end
            OP_WR:   ring_we = 1'b1;
            default: ring_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[waddr] <= wdata;
        rdata_reg <= ring[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            mul_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_window_reg <= WINDOW_RST;
            cfg_thresh_reg <= THRESHOLD_RST;
            cfg_smooth_reg <= SMOOTHING_RST;
            cfg_period_reg <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW:    cfg_window_reg <= cfg_data[8:0];
                REG_THRESHOLD: cfg_thresh_reg <= cfg_data[11:0];
                REG_SMOOTHING: cfg_smooth_reg <= cfg_data;
                REG_PERIOD:    cfg_period_reg <= cfg_data[15:0];
                default:       cfg_window_reg <= cfg_window_reg;
            endcase
        end
    end

    // persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            fill_reg    <= '0;
            pcnt_reg    <= '0;
            mean_reg    <= '0;
            var_reg     <= '0;
            idx_reg     <= '0;
            out_sig_reg <= SIG_NONE;
        end
        else
        begin
            case (cmd.op)
                OP_CLR:     idx_reg <= (idx_reg == LAST_A) ? '0 : idx_reg + 1'b1;
                OP_WR:      idx_reg <= '0;
                OP_SUM_ACC: idx_reg <= st.idx_last ? '0 : idx_reg + 1'b1;
                OP_VAR_ACC: idx_reg <= st.idx_last ? '0 : idx_reg + 1'b1;
                OP_MSET:    mean_reg <= (q > 64'(MEAN_MAX)) ? MEAN_MAX : q[31:0];
                OP_VSET:    var_reg <= (q > 64'(VAR_MAX)) ? VAR_MAX : q[47:0];
                OP_ISET:
                begin
                    mean_reg <= mnew_reg;
                    if (vacc_reg < 0)
                        var_reg <= '0;
                    else if (vacc_reg > signed'(64'(VAR_MAX)))
                        var_reg <= VAR_MAX;
                    else
                        var_reg <= vacc_reg[47:0];
                end
                OP_FINISH:
                begin
                    wp_reg <= (NW'(p_reg) + 1'b1 == n_reg) ? '0 : p_reg + 1'b1;
                    if (fill_reg < FILL_TOP)
                        fill_reg <= fill_reg + 1'b1;
                    pcnt_reg <= (pcnt_inc >= 17'(period_eff)) ? '0 : pcnt_inc[15:0];
                    if (!sig_reg)
                        out_sig_reg <= SIG_NONE;
                    else
                        out_sig_reg <= neg_reg ? SIG_NEG : SIG_POS;
                end
                default: idx_reg <= idx_reg;
            endcase
        end
    end

    // per transaction working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                y_reg    <= sample;
                n_reg    <= n_eff;
                p_reg    <= p_start;
                prev_reg <= prev_start;
            end
            OP_TH2:
            begin
                b_old_reg <= rdata_reg;
                d2_reg    <= mul_reg;
            end
            OP_TH2_CAP: th2_reg <= mul_reg[23:0];
            OP_VLO:
            begin
                hi_reg       <= mul_reg[47:0];
                prev_val_reg <= rdata_reg;
            end
            OP_CMP:
            begin
                // squared deviation against threshold squared times variance, once the fill count exceeds the window
                sig_reg <= (32'(fill_reg) > 32'(n_reg)) && (72'(d2_reg) > th_prod);
                neg_reg <= !dy_pos;
            end
            OP_PK1: acc_reg <= mul_reg[40:0];
            OP_PK2: b_new_reg <= sig_reg ? peak_acc[39:16] : {y_reg, 8'b0};
            OP_WR: sum_reg <= '0;
            OP_SUM_ACC: sum_reg <= sum_reg + 64'(rdata_reg);
            OP_MSET: sum_reg <= '0;
            OP_VAR_ACC: sum_reg <= sum_reg + 64'(mul_reg[63:16]);
            OP_DMSET:
            begin
                dm_neg_reg <= diff_neg && (q != '0);
                dmm_reg    <= q[31:0];
            end
            OP_MNEW:
            begin
                if (dm_neg_reg)
                    mnew_reg <= (mean_reg < dmm_reg) ? '0 : mean_reg - dmm_reg;
                else
                    mnew_reg <= mean_up[32] ? MEAN_MAX : mean_up[31:0];
            end
            OP_AACC: vacc_reg <= signed'(64'(var_reg)) - signed'(q);
            OP_BACC: vacc_reg <= vacc_reg + signed'(q);
            OP_TACC: vacc_reg <= (dm_neg_reg != eold_neg) ? vacc_reg - signed'(q)
                                                           : vacc_reg + signed'(q);
            OP_DX:   x_reg <= mul_reg[63:16];
            OP_DLO:  hi_reg <= mul_reg[47:0];
            OP_DACC: vacc_reg <= vacc_reg + signed'(q);
            default: acc_reg <= acc_reg;
        endcase
    end

    assign st.period_zero = pcnt_reg == 16'd0;
    assign st.idx_last    = NW'(idx_reg) == nm1;
    assign st.clr_last    = idx_reg == LAST_A;
    assign peak_signal    = out_sig_reg;

endmodule

@@ src/zpd_ctrl.sv @@
// controller: sequences the datapath through one transaction at a time
`include "assert_macros.svh"
module zpd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  zpd_pkg::dp_status_t st,
    output zpd_pkg::dp_cmd_t    cmd
);
    import zpd_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire, out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_CLEAR:    if (st.clr_last) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_RD_OLD;
            S_RD_OLD:   state_next = S_TH2;
            S_TH2:      state_next = S_TH2_CAP;
            S_TH2_CAP:  state_next = S_VHI;
            S_VHI:      state_next = S_VLO;
            S_VLO:      state_next = S_CMP;
            S_CMP:      state_next = S_PK1;
            S_PK1:      state_next = S_PK2;
            S_PK2:      state_next = S_WR;
            S_WR:       state_next = st.period_zero ? S_SUM_RD : S_DM;
            S_SUM_RD:   state_next = S_SUM_ACC;
            S_SUM_ACC:  state_next = st.idx_last ? S_MDIV : S_SUM_RD;
            S_MDIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_MSET;
            end
            S_DIV_WAIT: if (st.div_done) state_next = ret_reg;
            S_MSET:     state_next = S_VAR_RD;
            S_VAR_RD:   state_next = S_VAR_MUL;
            S_VAR_MUL:  state_next = S_VAR_ACC;
            S_VAR_ACC:  state_next = st.idx_last ? S_VDIV : S_VAR_RD;
            S_VDIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_VSET;
            end
            S_VSET:     state_next = S_DONE;
            S_DM:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_DMSET;
            end
            S_DMSET:    state_next = S_MNEW;
            S_MNEW:     state_next = S_ADIV;
            S_ADIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_AACC;
            end
            S_AACC:     state_next = S_BDIV;
            S_BDIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_BACC;
            end
            S_BACC:     state_next = S_TDIV;
            S_TDIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_TACC;
            end
            S_TACC:     state_next = S_DX;
            S_DX:       state_next = S_DHI;
            S_DHI:      state_next = S_DLO;
            S_DLO:      state_next = S_DDIV;
            S_DDIV:
            begin
                state_next = S_DIV_WAIT;
                ret_next   = S_DACC;
            end
            S_DACC:     state_next = S_ISET;
            S_ISET:     state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_MEAN;
        in_ready      = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.op = OP_CLR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_START;
            end
            S_RD_OLD:  cmd.op = OP_RD_OLD;
            S_TH2:     cmd.op = OP_TH2;
            S_TH2_CAP: cmd.op = OP_TH2_CAP;
            S_VHI:     cmd.op = OP_VHI;
            S_VLO:     cmd.op = OP_VLO;
            S_CMP:     cmd.op = OP_CMP;
            S_PK1:     cmd.op = OP_PK1;
            S_PK2:     cmd.op = OP_PK2;
            S_WR:      cmd.op = OP_WR;
            S_SUM_RD:  cmd.op = OP_SUM_RD;
            S_SUM_ACC: cmd.op = OP_SUM_ACC;
            S_MDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
            end
            S_MSET:    cmd.op = OP_MSET;
            S_VAR_RD:  cmd.op = OP_SUM_RD;
            S_VAR_MUL: cmd.op = OP_VAR_MUL;
            S_VAR_ACC: cmd.op = OP_VAR_ACC;
            S_VDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
            end
            S_VSET:    cmd.op = OP_VSET;
            S_DM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DM;
            end
            S_DMSET:   cmd.op = OP_DMSET;
            S_MNEW:    cmd.op = OP_MNEW;
            S_ADIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_A;
            end
            S_AACC:    cmd.op = OP_AACC;
            S_BDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_B;
            end
            S_BACC:    cmd.op = OP_BACC;
            S_TDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_T;
            end
            S_TACC:    cmd.op = OP_TACC;
            S_DX:      cmd.op = OP_DX;
            S_DHI:     cmd.op = OP_DHI;
            S_DLO:     cmd.op = OP_DLO;
            S_DDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_D;
            end
            S_DACC:    cmd.op = OP_DACC;
            S_ISET:    cmd.op = OP_ISET;
            S_DONE:    if (out_free) cmd.op = OP_FINISH;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == S_DONE && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ZPD_NEVER(a_div_restart, clk, rst_n, cmd.div_start && st.div_busy, "divider restarted while busy")
    `ZPD_ASSERT(a_accept_starts, clk, rst_n, in_fire |=> state_reg == S_RD_OLD, "accept did not start work")
    `ZPD_ASSERT(a_div_hold, clk, rst_n, (state_reg == S_DIV_WAIT && !st.div_done) |=> state_reg == S_DIV_WAIT, "left divider wait early")
    `ZPD_ASSERT(a_result_posted, clk, rst_n, (state_reg == S_DONE && out_free) |=> out_valid_reg, "result not posted")

endmodule

@@ src/zscore_peak_detector.sv @@
// top level of the smoothed zscore peak detector
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] sample
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[1:0] peak_signal (1, -1, 0)
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// one transaction at a time; the shared divider is bit-serial
// incremental update: 5 divides interleaved with datapath steps
// full recompute every recalc_period transactions: a sum pass and a variance pass over window n
// after reset a clearing pass zeroes all MAX_WINDOW ring entries before input is taken
// the result sits in an output register; a stalled m_axis only holds the next finish
module zscore_peak_detector #(
    parameter int MAX_WINDOW = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] peak_signal, [7:2] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import zpd_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       st;
    logic [SIG_W-1:0] peak_signal;

    assign cfg_ready = 1'b1;

    zpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    zpd_datapath #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .sample      (s_axis_tdata),
        .peak_signal (peak_signal),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    assign m_axis_tdata = {6'b0, peak_signal};

endmodule
